/* rtl/jcs_pkg.sv */
// ----------------------------------------------------------------------------
// JSON comment stripper package
// Scan modes, character codes, output queue sizing and the per-byte scan
// function used by the scan stage.
// ----------------------------------------------------------------------------
package jcs_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } t_mode;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Output queue: each scanned item pushes at most two words.
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    // Room needed: two words for the item in the input register, two for a new one.
    localparam logic [Q_CNT_W-1:0] Q_LIMIT_BUSY = Q_CNT_W'(Q_DEPTH - 4);
    localparam logic [Q_CNT_W-1:0] Q_LIMIT_IDLE = Q_CNT_W'(Q_DEPTH - 2);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic [1:0] cnt;
        t_entry     e0;
        t_entry     e1;
    } t_push;

    typedef struct packed {
        logic [7:0] data;
        logic       two;
        t_mode      mode;
        logic       esc;
    } t_scan;

    // Scans one byte against its lookahead. When two is set, the lookahead is
    // used up as well and the item yields two spaces.
    function automatic t_scan scan_byte(t_mode mode, logic esc,
                                        logic [7:0] ch, logic [7:0] nx);
        t_scan r;
        r.data = ch;
        r.two  = 1'b0;
        r.mode = mode;
        r.esc  = esc;
        unique case (mode)
            MODE_NORMAL: begin
                if (ch == CH_QUOTE) begin
                    r.mode = MODE_STRING;
                end else if (ch == CH_SLASH && (nx == CH_SLASH || nx == CH_STAR)) begin
                    r.data = CH_SPACE;
                    r.two  = 1'b1;
                    r.mode = (nx == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                end
            end
            MODE_STRING: begin
                if (esc) begin
                    r.esc = 1'b0;
                end else if (ch == CH_BSLASH) begin
                    r.esc = 1'b1;
                end else if (ch == CH_QUOTE) begin
                    r.mode = MODE_NORMAL;
                end
            end
            MODE_LINE: begin
                if (ch == CH_LF || ch == CH_CR) begin
                    r.mode = MODE_NORMAL;
                end else begin
                    r.data = CH_SPACE;
                end
            end
            MODE_BLOCK: begin
                if (ch == CH_STAR && nx == CH_SLASH) begin
                    r.data = CH_SPACE;
                    r.two  = 1'b1;
                    r.mode = MODE_NORMAL;
                end else if (!(ch == CH_LF || ch == CH_CR)) begin
                    r.data = CH_SPACE;
                end
            end
            default: begin
                r.mode = MODE_NORMAL;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/json_comment_stripper_top.sv */
// ----------------------------------------------------------------------------
// JSON comment stripper
// Replaces line and block comments in a JSON text by spaces, one byte a word.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_data_byte, i_end_of_text
//   output   out        o_valid / i_stall   o_clean_byte, o_final_byte
//
// One input word is taken every cycle while o_stall is low; a byte reaches
// the output only after its successor or the end of the text arrives, as every
// byte is scanned against its successor (input register, scan stage, output queue).
// An eight-word output queue absorbs cycles in which two words are produced;
// o_stall rises only when the output side has stalled long enough for the
// queue to hold more than four words, or six while the input register is empty.
// Reset is synchronous and active low and returns the scanner to normal mode.
// ----------------------------------------------------------------------------
module json_comment_stripper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_clean_byte,
    output logic        o_final_byte
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_data;
    logic                         r_in_eot;
    logic                         in_accept;
    jcs_pkg::t_push               push;
    jcs_pkg::t_entry              head;
    logic [jcs_pkg::Q_CNT_W-1:0]  q_count;

    // Leave room for two words from the registered item and two from a new one.
    assign o_stall   = r_in_valid ? (q_count > jcs_pkg::Q_LIMIT_BUSY)
                                  : (q_count > jcs_pkg::Q_LIMIT_IDLE);
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_data_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    jcs_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item_data  (r_in_data),
        .i_item_eot   (r_in_eot),
        .o_push       (push)
    );

    jcs_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop_ready  (!i_stall),
        .o_valid      (o_valid),
        .o_head       (head),
        .o_count      (q_count)
    );

    assign o_clean_byte = head.data;
    assign o_final_byte = head.last;

endmodule

/* rtl/jcs_scan.sv */
// ----------------------------------------------------------------------------
// JSON comment stripper scan stage
// Holds the scan mode, escape flag and pending byte, and turns one registered
// input byte into zero, one or two output words per cycle.
// ----------------------------------------------------------------------------
module jcs_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  logic [7:0]      i_item_data,
    input  logic            i_item_eot,
    output jcs_pkg::t_push  o_push
);

    jcs_pkg::t_mode r_mode, n_mode;
    logic           r_esc, n_esc;
    logic           r_held_valid, n_held_valid;
    logic [7:0]     r_held_data, n_held_data;

    jcs_pkg::t_scan first;
    jcs_pkg::t_scan second;
    jcs_pkg::t_mode mid_mode;
    logic           mid_esc;
    logic           pending;

    // The held byte is scanned with the incoming byte as lookahead; at the end
    // of a text the incoming byte is then scanned against a NUL lookahead.
    always_comb begin
        first    = jcs_pkg::scan_byte(r_mode, r_esc, r_held_data, i_item_data);
        mid_mode = r_held_valid ? first.mode : r_mode;
        mid_esc  = r_held_valid ? first.esc : r_esc;
        second   = jcs_pkg::scan_byte(mid_mode, mid_esc, i_item_data, jcs_pkg::CH_NUL);
        pending  = !(r_held_valid && first.two);
    end

    always_comb begin
        n_mode       = r_mode;
        n_esc        = r_esc;
        n_held_valid = r_held_valid;
        n_held_data  = r_held_data;
        if (i_item_valid) begin
            if (i_item_eot) begin
                n_mode       = jcs_pkg::MODE_NORMAL;
                n_esc        = 1'b0;
                n_held_valid = 1'b0;
                n_held_data  = 8'h00;
            end else begin
                n_mode       = mid_mode;
                n_esc        = mid_esc;
                n_held_valid = pending;
                n_held_data  = pending ? i_item_data : 8'h00;
            end
        end
    end

    always_comb begin
        o_push = '0;
        if (i_item_valid) begin
            if (r_held_valid) begin
                o_push.e0.data = first.data;
                if (first.two) begin
                    o_push.e1.data = jcs_pkg::CH_SPACE;
                    o_push.e1.last = i_item_eot;
                    o_push.cnt     = 2'd2;
                end else if (i_item_eot) begin
                    o_push.e1.data = second.data;
                    o_push.e1.last = 1'b1;
                    o_push.cnt     = 2'd2;
                end else begin
                    o_push.cnt = 2'd1;
                end
            end else if (i_item_eot) begin
                o_push.e0.data = second.data;
                o_push.e0.last = 1'b1;
                o_push.cnt     = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= jcs_pkg::MODE_NORMAL;
            r_esc        <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_data  <= 8'h00;
        end else begin
            r_mode       <= n_mode;
            r_esc        <= n_esc;
            r_held_valid <= n_held_valid;
            r_held_data  <= n_held_data;
        end
    end

endmodule

/* rtl/jcs_outq.sv */
// ----------------------------------------------------------------------------
// JSON comment stripper output queue
// Small queue that takes up to two words a cycle and presents one word a
// cycle to the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module jcs_outq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  jcs_pkg::t_push               i_push,
    input  logic                         i_pop_ready,
    output logic                         o_valid,
    output jcs_pkg::t_entry              o_head,
    output logic [jcs_pkg::Q_CNT_W-1:0]  o_count
);

    jcs_pkg::t_entry                r_mem [jcs_pkg::Q_DEPTH];
    logic [jcs_pkg::Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [jcs_pkg::Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [jcs_pkg::Q_CNT_W-1:0]    r_count, n_count;
    logic [jcs_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic                           pop;

    assign o_valid     = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign o_count     = r_count;
    assign pop         = o_valid && i_pop_ready;
    assign wr_ptr_next = r_wr_ptr + jcs_pkg::Q_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + jcs_pkg::Q_PTR_W'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + jcs_pkg::Q_PTR_W'(pop);
        n_count  = r_count + jcs_pkg::Q_CNT_W'(i_push.cnt) - jcs_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.e0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/jcs_checker.sv */
// ----------------------------------------------------------------------------
// JSON comment stripper port checker
// Watches the top-level ports: output after reset, hold under stall, balance of
// words taken in against words given out, and an idle output once a text drains.
// ----------------------------------------------------------------------------
module jcs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_clean_byte,
    input  logic        o_final_byte
);

    logic [4:0] r_balance;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Words inside the block: input register, pending byte and queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balance <= '0;
        end else begin
            r_balance <= r_balance + 5'(in_acc) - 5'(out_acc);
        end
    end

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_clean_byte) && $stable(o_final_byte)))
        else $error("stalled output word changed");

    a_no_invented_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_balance != 5'd0))
        else $error("output word without a matching input word");

    a_bounded_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_balance <= 5'd10)
        else $error("more words held than the block can store");

    a_final_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_final_byte && !in_acc && r_balance == 5'd1) |=> !o_valid)
        else $error("output still valid after the last word of a drained text");

endmodule

bind json_comment_stripper_top jcs_checker u_jcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_clean_byte  (o_clean_byte),
    .o_final_byte  (o_final_byte)
);

/* bench/json_comment_stripper_top_tb.sv */
// ----------------------------------------------------------------------------
// JSON comment stripper testbench
// Sends short JSON-like texts, directed ones first and then random ones built
// from strings, comments, plain tokens and noise bytes. The sender runs in
// bursts and the receiver stalls on its own pattern, holding off once for a
// long stretch. Every accepted output word is checked against a byte-level
// model of the stripper kept in a small scoreboard.
// ----------------------------------------------------------------------------
module json_comment_stripper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_LIMIT  = 100;

    // Model of the stripper and the store of words it says must come out.
    class clean_text_board;
        jcs_pkg::t_mode  mode;
        bit              in_escape;
        bit              have_held;
        logic [7:0]      held;
        jcs_pkg::t_entry step_words[$];
        jcs_pkg::t_entry words_due[$];
        int              errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            mode      = jcs_pkg::MODE_NORMAL;
            in_escape = 1'b0;
            have_held = 1'b0;
            held      = 8'h00;
        endfunction

        function void emit(logic [7:0] b);
            jcs_pkg::t_entry w;
            w.data = b;
            w.last = 1'b0;
            step_words.push_back(w);
        endfunction

        // Scans one byte against the byte after it; returns 1 when that byte
        // has been swallowed as the second half of a comment marker.
        function bit scan_char(logic [7:0] ch, logic [7:0] nx);
            bit swallowed;
            swallowed = 1'b0;
            case (mode)
                jcs_pkg::MODE_NORMAL: begin
                    if (ch == jcs_pkg::CH_QUOTE) begin
                        emit(ch);
                        mode = jcs_pkg::MODE_STRING;
                    end else if (ch == jcs_pkg::CH_SLASH &&
                                 (nx == jcs_pkg::CH_SLASH || nx == jcs_pkg::CH_STAR)) begin
                        emit(jcs_pkg::CH_SPACE);
                        emit(jcs_pkg::CH_SPACE);
                        mode = (nx == jcs_pkg::CH_SLASH) ? jcs_pkg::MODE_LINE
                                                         : jcs_pkg::MODE_BLOCK;
                        swallowed = 1'b1;
                    end else begin
                        emit(ch);
                    end
                end
                jcs_pkg::MODE_STRING: begin
                    emit(ch);
                    if (in_escape) in_escape = 1'b0;
                    else if (ch == jcs_pkg::CH_BSLASH) in_escape = 1'b1;
                    else if (ch == jcs_pkg::CH_QUOTE) mode = jcs_pkg::MODE_NORMAL;
                end
                jcs_pkg::MODE_LINE: begin
                    if (ch == jcs_pkg::CH_LF || ch == jcs_pkg::CH_CR) begin
                        emit(ch);
                        mode = jcs_pkg::MODE_NORMAL;
                    end else begin
                        emit(jcs_pkg::CH_SPACE);
                    end
                end
                default: begin
                    if (ch == jcs_pkg::CH_STAR && nx == jcs_pkg::CH_SLASH) begin
                        emit(jcs_pkg::CH_SPACE);
                        emit(jcs_pkg::CH_SPACE);
                        mode = jcs_pkg::MODE_NORMAL;
                        swallowed = 1'b1;
                    end else if (ch == jcs_pkg::CH_LF || ch == jcs_pkg::CH_CR) begin
                        emit(ch);
                    end else begin
                        emit(jcs_pkg::CH_SPACE);
                    end
                end
            endcase
            return swallowed;
        endfunction

        function void note_input(logic [7:0] b, logic eot);
            bit swallowed;
            swallowed = 1'b0;
            step_words.delete();
            if (have_held) swallowed = scan_char(held, b);
            if (eot) begin
                // The end of the text flushes with a NUL lookahead.
                if (!swallowed) void'(scan_char(b, jcs_pkg::CH_NUL));
                if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
                clear_scan();
            end else if (swallowed) begin
                have_held = 1'b0;
                held      = 8'h00;
            end else begin
                have_held = 1'b1;
                held      = b;
            end
            foreach (step_words[i]) words_due.push_back(step_words[i]);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] b, logic fin);
            jcs_pkg::t_entry w;
            if (words_due.size() == 0) begin
                report($sformatf("unexpected word %02h final %0b", b, fin));
            end else begin
                w = words_due.pop_front();
                if (b !== w.data)
                    report($sformatf("clean_byte %02h, expected %02h", b, w.data));
                if (fin !== w.last)
                    report($sformatf("final_byte %0b, expected %0b", fin, w.last));
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_end_of_text;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_clean_byte;
    logic       o_final_byte;

    clean_text_board board = new();
    logic [7:0]      text_buf[$];
    int              burst_left = 0;
    int              items_sent = 0;
    bit              hold_request = 1'b0;
    int              cycle_count = 0;

    json_comment_stripper_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_clean_byte  (o_clean_byte),
        .o_final_byte  (o_final_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_clean_byte, o_final_byte);
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** json_comment_stripper_top: FAILED **");
        $finish;
    end

    // The receiver changes its stall style every so often and honours one
    // long hold-off request from the stimulus.
    initial begin : receiver
        int style_left;
        int style;
        int tick;
        style_left = 0;
        style      = 0;
        tick       = 0;
        i_stall    = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_stall = 1'b1;
                end
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(10, 60);
            end
            style_left--;
            tick++;
            @(negedge i_clk);
            case (style)
                0:       i_stall = 1'b0;
                1:       i_stall = ($urandom_range(0, 3) == 0);
                2:       i_stall = ($urandom_range(0, 3) != 0);
                default: i_stall = (tick % 4 == 0);
            endcase
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_data_byte   = b;
        i_end_of_text = eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(b, eot);
        items_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return "a";
            1:       return jcs_pkg::CH_SLASH;
            2:       return jcs_pkg::CH_STAR;
            3:       return jcs_pkg::CH_QUOTE;
            4:       return jcs_pkg::CH_BSLASH;
            5:       return jcs_pkg::CH_LF;
            6:       return jcs_pkg::CH_CR;
            7:       return jcs_pkg::CH_SPACE;
            8:       return 8'($urandom_range(0, 255));
            default: return jcs_pkg::CH_NUL;
        endcase
    endfunction

    // Appends one piece of text: mostly well-formed strings and comments,
    // with plain tokens, stray markers and noise bytes mixed in.
    function automatic void add_fragment();
        int n;
        logic [7:0] b;
        n = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0, 1: begin
                text_buf.push_back(jcs_pkg::CH_QUOTE);
                repeat (n) begin
                    b = pick_char();
                    if (b == jcs_pkg::CH_BSLASH) begin
                        text_buf.push_back(b);
                        b = ($urandom_range(0, 1) == 0) ? jcs_pkg::CH_QUOTE : pick_char();
                    end else if (b == jcs_pkg::CH_QUOTE) begin
                        b = "s";
                    end
                    text_buf.push_back(b);
                end
                if ($urandom_range(0, 9) != 0) text_buf.push_back(jcs_pkg::CH_QUOTE);
            end
            2: begin
                text_buf.push_back(jcs_pkg::CH_SLASH);
                text_buf.push_back(jcs_pkg::CH_SLASH);
                repeat (n) begin
                    b = pick_char();
                    if (b == jcs_pkg::CH_LF || b == jcs_pkg::CH_CR) b = "c";
                    text_buf.push_back(b);
                end
                if ($urandom_range(0, 9) != 0)
                    text_buf.push_back(($urandom_range(0, 1) == 0) ? jcs_pkg::CH_LF
                                                                   : jcs_pkg::CH_CR);
            end
            3, 4: begin
                text_buf.push_back(jcs_pkg::CH_SLASH);
                text_buf.push_back(jcs_pkg::CH_STAR);
                repeat (n) text_buf.push_back(pick_char());
                if ($urandom_range(0, 9) != 0) begin
                    text_buf.push_back(jcs_pkg::CH_STAR);
                    text_buf.push_back(jcs_pkg::CH_SLASH);
                end
            end
            5, 6: begin
                repeat (n + 1) begin
                    case ($urandom_range(0, 5))
                        0:       text_buf.push_back("{");
                        1:       text_buf.push_back("}");
                        2:       text_buf.push_back(":");
                        3:       text_buf.push_back(",");
                        4:       text_buf.push_back("1");
                        default: text_buf.push_back(jcs_pkg::CH_SPACE);
                    endcase
                end
            end
            7: begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
                case ($urandom_range(0, 2))
                    0:       text_buf.push_back(jcs_pkg::CH_SLASH);
                    1:       text_buf.push_back(jcs_pkg::CH_STAR);
                    default: text_buf.push_back(jcs_pkg::CH_QUOTE);
                endcase
            end
            default: text_buf.push_back(jcs_pkg::CH_NUL);
        endcase
    endfunction

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = 8'h00;
        i_end_of_text = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A one-byte text, then a NUL followed by a slash at the very end.
        text_buf = '{8'hFF};
        send_text();
        text_buf = '{jcs_pkg::CH_NUL, jcs_pkg::CH_SLASH};
        send_text();
        // A string holding an escaped quote and a pair of slashes.
        text_buf = '{jcs_pkg::CH_QUOTE, jcs_pkg::CH_BSLASH, jcs_pkg::CH_QUOTE,
                     jcs_pkg::CH_SLASH, jcs_pkg::CH_SLASH, jcs_pkg::CH_QUOTE, "x"};
        send_text();
        // A line comment ended by CR, a block comment holding LF, a NUL byte.
        text_buf = '{jcs_pkg::CH_SLASH, jcs_pkg::CH_SLASH, "a", jcs_pkg::CH_CR,
                     jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR, jcs_pkg::CH_LF,
                     jcs_pkg::CH_STAR, jcs_pkg::CH_SLASH, jcs_pkg::CH_NUL};
        send_text();
        // A block comment left open at the end of the text.
        text_buf = '{jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR, jcs_pkg::CH_STAR};
        send_text();

        hold_request = 1'b1;
        items_sent   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            text_buf.delete();
            repeat ($urandom_range(1, 3)) add_fragment();
            send_text();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("** json_comment_stripper_top: PASSED **");
        end else begin
            $display("** json_comment_stripper_top: FAILED **");
        end
        $finish;
    end

endmodule

/* json_comment_stripper_top.f */
rtl/jcs_pkg.sv
rtl/jcs_scan.sv
rtl/jcs_outq.sv
rtl/json_comment_stripper_top.sv
rtl/jcs_checker.sv
bench/json_comment_stripper_top_tb.sv
